// ===== rtl/text_console_cursor_scroll_defines.svh =====
// assertion macros for the text console cursor and scroll engine
// used by the top level only; expects clk and rst in scope
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// condition holds at every clock edge out of reset
`define TCCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tccs_pkg.sv =====
// shared types, constants and microcode fields of the text console engine
// no dependencies; imported by every module of the block
package tccs_pkg;

  // screen geometry
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
  localparam int TAB_STOP     = 8;

  // field widths
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int DATA_W  = 16;
  localparam int MODE_W  = 2;
  localparam int STEP_W  = 4;

  // stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = MODE_W;
  localparam int M_TDATA_W = 40;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT,
    MODE_CLEAR_SCREEN,
    MODE_CLEAR_ROW,
    MODE_READ
  } mode_t;

  // pointer range loads
  typedef enum logic [2:0] {
    PTR_NONE,
    PTR_ALL,
    PTR_SCROLL,
    PTR_LASTROW,
    PTR_CURROW
  } ptr_sel_t;

  // cursor updates
  typedef enum logic [1:0] {
    CUR_NONE,
    CUR_PUT,
    CUR_HOME_ROW,
    CUR_ZERO_COL
  } cur_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_DISPATCH,
    COND_SCROLL,
    COND_LAST,
    COND_OUT_FREE
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram step addresses
  localparam step_t STEP_CLR_INIT   = 4'd0;
  localparam step_t STEP_CLR_FILL   = 4'd1;
  localparam step_t STEP_IDLE       = 4'd2;
  localparam step_t STEP_PUT        = 4'd3;
  localparam step_t STEP_EMIT       = 4'd4;
  localparam step_t STEP_SCR_INIT   = 4'd5;
  localparam step_t STEP_SCR_COPY   = 4'd6;
  localparam step_t STEP_SCR_TAIL   = 4'd7;
  localparam step_t STEP_FILL_BLANK = 4'd8;
  localparam step_t STEP_CLR_SCREEN = 4'd9;
  localparam step_t STEP_CLR_ROW    = 4'd10;
  localparam step_t STEP_READ       = 4'd11;

  // datapath half of a control word
  typedef struct packed {
    logic     ready;
    ptr_sel_t ptr_sel;
    logic     fill;
    logic     fill_blank;
    logic     copy;
    logic     read;
    cur_op_t  cur_op;
    logic     emit;
  } dp_ctrl_t;

  // full control word
  typedef struct packed {
    dp_ctrl_t dp;
    cond_t    cond;
    logic     hold;
    step_t    target;
  } ucode_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic  accept;
    mode_t mode;
    logic  scroll;
    logic  last;
    logic  out_free;
  } dp_status_t;

  // screen memory request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // entry step for each mode
  function automatic step_t dispatch_step(mode_t mode);
    step_t s;
    case (mode)
      MODE_PUT:          s = STEP_PUT;
      MODE_CLEAR_SCREEN: s = STEP_CLR_SCREEN;
      MODE_CLEAR_ROW:    s = STEP_CLR_ROW;
      MODE_READ:         s = STEP_READ;
      default:           s = STEP_IDLE;
    endcase
    return s;
  endfunction

  // first cell of a row
  function automatic logic [ADDR_W-1:0] row_base(logic [ROW_W-1:0] row);
    return ADDR_W'(row) * ADDR_W'(COLUMNS);
  endfunction

endpackage

// ===== rtl/tccs_screen_ram.sv =====
// screen cell store, one write port and one registered read port
// depends on tccs_pkg
module tccs_screen_ram import tccs_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CELLS];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/tccs_useq.sv =====
// microcode sequencer: step counter, control store and jump logic
// depends on tccs_pkg; drives the datapath control word
module tccs_useq import tccs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl
);

  step_t  pc;
  step_t  pc_next;
  ucode_t uc;
  logic   cond_true;
  step_t  jump_to;

  // control store
  always_comb begin
    uc        = '0;
    uc.cond   = COND_ALWAYS;
    uc.target = STEP_IDLE;
    case (pc)
      STEP_CLR_INIT: begin
        uc.dp.ptr_sel = PTR_ALL;
        uc.target     = STEP_CLR_FILL;
      end
      STEP_CLR_FILL: begin
        uc.dp.fill = 1'b1;
        uc.cond    = COND_LAST;
        uc.hold    = 1'b1;
        uc.target  = STEP_IDLE;
      end
      STEP_IDLE: begin
        uc.dp.ready = 1'b1;
        uc.cond     = COND_DISPATCH;
        uc.hold     = 1'b1;
      end
      STEP_PUT: begin
        uc.dp.cur_op = CUR_PUT;
        uc.cond      = COND_SCROLL;
        uc.target    = STEP_SCR_INIT;
      end
      STEP_EMIT: begin
        uc.dp.emit = 1'b1;
        uc.cond    = COND_OUT_FREE;
        uc.hold    = 1'b1;
        uc.target  = STEP_IDLE;
      end
      STEP_SCR_INIT: begin
        uc.dp.ptr_sel = PTR_SCROLL;
        uc.target     = STEP_SCR_COPY;
      end
      STEP_SCR_COPY: begin
        uc.dp.copy = 1'b1;
        uc.cond    = COND_LAST;
        uc.hold    = 1'b1;
        uc.target  = STEP_SCR_TAIL;
      end
      STEP_SCR_TAIL: begin
        uc.dp.ptr_sel = PTR_LASTROW;
        uc.target     = STEP_FILL_BLANK;
      end
      STEP_FILL_BLANK: begin
        uc.dp.fill       = 1'b1;
        uc.dp.fill_blank = 1'b1;
        uc.cond          = COND_LAST;
        uc.hold          = 1'b1;
        uc.target        = STEP_EMIT;
      end
      STEP_CLR_SCREEN: begin
        uc.dp.ptr_sel = PTR_ALL;
        uc.dp.cur_op  = CUR_HOME_ROW;
        uc.target     = STEP_FILL_BLANK;
      end
      STEP_CLR_ROW: begin
        uc.dp.ptr_sel = PTR_CURROW;
        uc.dp.cur_op  = CUR_ZERO_COL;
        uc.target     = STEP_FILL_BLANK;
      end
      STEP_READ: begin
        uc.dp.read = 1'b1;
        uc.target  = STEP_EMIT;
      end
      default: begin
        uc.target = STEP_IDLE;
      end
    endcase
  end

  // jump condition select
  always_comb begin
    case (uc.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_DISPATCH: cond_true = status.accept;
      COND_SCROLL:   cond_true = status.scroll;
      COND_LAST:     cond_true = status.last;
      COND_OUT_FREE: cond_true = status.out_free;
      default:       cond_true = 1'b1;
    endcase
    jump_to = (uc.cond == COND_DISPATCH) ? dispatch_step(status.mode) : uc.target;
  end

  // next step
  always_comb begin
    if (cond_true) begin
      pc_next = jump_to;
    end else if (uc.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_CLR_INIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl = uc.dp;

endmodule

// ===== rtl/tccs_datapath.sv =====
// datapath: input latch, cursor, cell pointer, memory port mux, output register
// depends on tccs_pkg; controlled by tccs_useq, drives tccs_screen_ram
module tccs_datapath import tccs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_ctrl_t             ctrl,
  output dp_status_t           status,
  input  logic                 cfg_we,
  input  logic [ATTR_W-1:0]    cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output mem_req_t             mem_req,
  input  logic [DATA_W-1:0]    mem_rdata
);

  logic [ATTR_W-1:0] attr;
  mode_t             mode_q;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] addr_q;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] last;
  logic              copy_d;
  logic [ADDR_W-1:0] copy_addr;

  logic              accept;
  logic              addr_ok;
  logic [ADDR_W-1:0] cur_pos;
  logic [ADDR_W-1:0] base;
  logic [COL_W-1:0]  tab_col;
  logic [COL_W-1:0]  put_col;
  logic              put_inc;
  logic              put_wr;
  logic [ROW_W-1:0]  put_row_t;
  logic              put_scroll;
  logic [ROW_W-1:0]  put_row;
  logic              out_free;
  logic              out_load;
  logic [DATA_W-1:0] read_val;

  assign s_tready = ctrl.ready;
  assign accept   = ctrl.ready & s_tvalid;
  assign addr_ok  = addr_q < ADDR_W'(CELLS);
  assign base     = row_base(row);
  assign cur_pos  = base + ADDR_W'(col);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ctrl.emit && out_free;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_wdata;
    end
  end

  // input transaction latch
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode_t'(s_tuser[MODE_W-1:0]);
      char_q <= s_tdata[CHAR_W-1:0];
      addr_q <= s_tdata[CHAR_W +: ADDR_W];
    end
  end

  // character interpretation
  always_comb begin
    tab_col = (col + COL_W'(TAB_STOP)) & ~COL_W'(TAB_STOP - 1);
    put_col = col;
    put_inc = 1'b0;
    put_wr  = 1'b0;
    case (char_q)
      CHAR_BS: begin
        if (col != '0) begin
          put_col = col - COL_W'(1);
        end
      end
      CHAR_TAB: begin
        put_col = tab_col;
      end
      CHAR_CR: begin
        put_col = '0;
      end
      CHAR_LF: begin
        put_col = '0;
        put_inc = 1'b1;
      end
      default: begin
        if (!char_q[CHAR_W-1] && char_q >= CHAR_SPACE) begin
          put_wr  = 1'b1;
          put_col = col + COL_W'(1);
        end
      end
    endcase
    // wrap at the right edge
    if (put_col >= COL_W'(COLUMNS)) begin
      put_col = '0;
      put_inc = 1'b1;
    end
    put_row_t  = row + ROW_W'(put_inc);
    put_scroll = put_row_t >= ROW_W'(ROWS);
    put_row    = put_scroll ? ROW_W'(ROWS - 1) : put_row_t;
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      case (ctrl.cur_op)
        CUR_PUT: begin
          col <= put_col;
          row <= put_row;
        end
        CUR_HOME_ROW: begin
          row <= '0;
        end
        CUR_ZERO_COL: begin
          col <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // cell pointer and end of range
  always_ff @(posedge clk) begin
    case (ctrl.ptr_sel)
      PTR_ALL: begin
        ptr  <= '0;
        last <= ADDR_W'(CELLS - 1);
      end
      PTR_SCROLL: begin
        ptr  <= '0;
        last <= ADDR_W'(SCROLL_CELLS - 1);
      end
      PTR_LASTROW: begin
        ptr  <= ADDR_W'(SCROLL_CELLS);
        last <= ADDR_W'(CELLS - 1);
      end
      PTR_CURROW: begin
        ptr  <= base;
        last <= base + ADDR_W'(COLUMNS - 1);
      end
      default: begin
        if (ctrl.fill || ctrl.copy) begin
          ptr <= ptr + ADDR_W'(1);
        end
      end
    endcase
  end

  // scroll copy: write back in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_d <= 1'b0;
    end else begin
      copy_d <= ctrl.copy;
    end
  end

  always_ff @(posedge clk) begin
    copy_addr <= ptr;
  end

  // memory port mux
  always_comb begin
    mem_req       = '0;
    mem_req.waddr = ptr;
    mem_req.raddr = ptr + ADDR_W'(COLUMNS);
    if (copy_d) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = copy_addr;
      mem_req.wdata = mem_rdata;
    end else if (ctrl.fill) begin
      mem_req.we    = 1'b1;
      mem_req.wdata = ctrl.fill_blank ? {attr, CHAR_SPACE} : '0;
    end else if (ctrl.cur_op == CUR_PUT && put_wr) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = cur_pos;
      mem_req.wdata = {attr, char_q};
    end
    if (ctrl.copy) begin
      mem_req.re = 1'b1;
    end else if (ctrl.read) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = addr_ok ? addr_q : '0;
    end
  end

  // output register
  assign read_val = (mode_q == MODE_READ && addr_ok) ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, read_val, row, col, cur_pos};
    end
  end

  // flags for the sequencer
  always_comb begin
    status.accept   = accept;
    status.mode     = mode_t'(s_tuser[MODE_W-1:0]);
    status.scroll   = put_scroll;
    status.last     = ptr == last;
    status.out_free = out_free;
  end

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// top level of the text console engine with cursor and scrolling
// depends on tccs_pkg, tccs_useq, tccs_datapath, tccs_screen_ram and the defines header
//
//   channel   signals                         content
//   s_axis    tvalid tready tdata tuser       one console command
//   m_axis    tvalid tready tdata             cursor after the command, read cell
//   cfg       cfg_we cfg_wdata                attribute byte, no wait
//
// put character and read cell pass through the sequencer steps accept, execute and emit
// a put that scrolls copies one cell per cycle, then blanks the last row
// clear screen and clear row blank one cell per cycle on the write port
// after rst the store is zeroed with tready low; cfg writes are taken
// a stalled result is held in the output register; the next command is still accepted
module text_console_cursor_scroll import tccs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [ATTR_W-1:0]    cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // char_code[7:0], read_address[18:8], zero pad [23:19]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // cursor_position[10:0], cursor_column[17:11], cursor_row[22:18],
  // read_data[38:23], zero pad [39]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  dp_ctrl_t          ctrl;
  dp_status_t        status;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  // sequencer
  tccs_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // datapath
  tccs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // screen store
  tccs_screen_ram u_screen_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // checks on the result fields
  logic [ADDR_W-1:0] out_pos;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [ADDR_W-1:0] calc_pos;
  logic              out_in_range;

  assign out_pos      = m_axis_tdata[ADDR_W-1:0];
  assign out_col      = m_axis_tdata[ADDR_W +: COL_W];
  assign out_row      = m_axis_tdata[ADDR_W + COL_W +: ROW_W];
  assign calc_pos     = row_base(out_row) + ADDR_W'(out_col);
  assign out_in_range = out_col < COL_W'(COLUMNS) && out_row < ROW_W'(ROWS);

  `include "text_console_cursor_scroll_defines.svh"

  `TCCS_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready held after a transaction")
  `TCCS_ASSERT_ALWAYS(a_cursor_in_range, !m_axis_tvalid || out_in_range, "cursor outside the screen")
  `TCCS_ASSERT_ALWAYS(a_position_matches, !m_axis_tvalid || out_pos == calc_pos, "position does not match row and column")

endmodule

// ===== verif/text_console_cursor_scroll_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the text console cursor and scroll engine
// depends on tccs_pkg and text_console_cursor_scroll; predictor or typed table checks results
module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam logic [CHAR_W-1:0] CHAR_LAST_PRINTABLE = 8'h7F;
  localparam logic [CHAR_W-1:0] CHAR_FIRST_HIGH     = 8'h80;
  localparam int ADDR_SPAN     = 1 << ADDR_W;
  // extra quiet time before the attribute changes
  localparam int SETTLE_CYCLES = 2100;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 100;
  localparam int PRINT_LIMIT   = 40;
  localparam longint WATCHDOG_NS = 64'd65_000_000;

  // one result, last field in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [ADDR_W-1:0] position;
  } cursor_result_t;

  localparam int RESULT_W = $bits(cursor_result_t);

  typedef struct {
    mode_t             mode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] address;
    bit                typed;
    cursor_result_t    want;
  } command_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [ATTR_W-1:0]    cfg_wdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // shadow copy of the console state
  logic [DATA_W-1:0] screen_shadow [CELLS];
  int                column_shadow;
  int                row_shadow;
  logic [ATTR_W-1:0] attribute_shadow;

  cursor_result_t pending_results [$];
  int             mismatch_count;
  int             commands_counted;
  bit             calm;

  command_row_t directed_rows [23];

  text_console_cursor_scroll dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // mostly no pause, some short ones, a few long ones
  function automatic int random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // next console state and result for one command
  function automatic cursor_result_t predict_console(mode_t mode, logic [CHAR_W-1:0] ch,
                                                     logic [ADDR_W-1:0] address);
    cursor_result_t r;
    logic [DATA_W-1:0] blank;
    int k;
    blank = {attribute_shadow, CHAR_SPACE};
    r = '0;
    case (mode)
      MODE_PUT: begin
        if (ch == CHAR_BS) begin
          if (column_shadow != 0) column_shadow--;
        end else if (ch == CHAR_TAB) begin
          column_shadow = ((column_shadow + TAB_STOP) & ~(TAB_STOP - 1)) & 'h7F;
        end else if (ch == CHAR_CR) begin
          column_shadow = 0;
        end else if (ch == CHAR_LF) begin
          column_shadow = 0;
          row_shadow++;
        end else if (ch >= CHAR_SPACE && ch <= CHAR_LAST_PRINTABLE) begin
          k = row_shadow * COLUMNS + column_shadow;
          if (k < CELLS) screen_shadow[k] = {attribute_shadow, ch};
          column_shadow++;
        end
        // wrap at the right edge, then scroll past the bottom row
        if (column_shadow >= COLUMNS) begin
          column_shadow = 0;
          row_shadow++;
        end
        if (row_shadow >= ROWS) begin
          for (int i = 0; i < SCROLL_CELLS; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
          for (int i = SCROLL_CELLS; i < CELLS; i++) screen_shadow[i] = blank;
          row_shadow = ROWS - 1;
        end
      end
      MODE_CLEAR_SCREEN: begin
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = blank;
        row_shadow = 0;
      end
      MODE_CLEAR_ROW: begin
        for (int i = 0; i < COLUMNS; i++) begin
          k = row_shadow * COLUMNS + i;
          if (k < CELLS) screen_shadow[k] = blank;
        end
        column_shadow = 0;
      end
      default: begin
        if (address < CELLS) r.read_data = screen_shadow[address];
      end
    endcase
    r.position = ADDR_W'(row_shadow * COLUMNS + column_shadow);
    r.column   = COL_W'(column_shadow);
    r.row      = ROW_W'(row_shadow);
    return r;
  endfunction

  // drive one command and record its expected result once it is taken
  task automatic send_command(input mode_t mode, input logic [CHAR_W-1:0] ch,
                              input logic [ADDR_W-1:0] address, input bit typed,
                              input cursor_result_t want);
    int gap;
    cursor_result_t predicted;
    bit no_effect;
    gap = random_pause();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= S_TDATA_W'({address, ch});
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_console(mode, ch, address);
    pending_results.push_back(typed ? want : predicted);
    // other control codes and high bytes leave everything as it was
    no_effect = (mode == MODE_PUT) && (ch >= CHAR_FIRST_HIGH ||
                (ch < CHAR_SPACE && ch != CHAR_BS && ch != CHAR_TAB &&
                 ch != CHAR_CR && ch != CHAR_LF));
    if (!no_effect) commands_counted++;
  endtask

  task automatic send_random_run();
    int kind;
    int len;
    int r;
    int base_row;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] address;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      // single command of any kind
      r = $urandom_range(0, 999);
      address = ADDR_W'($urandom_range(0, ADDR_SPAN - 1));
      if (r < 15) begin
        send_command(MODE_CLEAR_SCREEN, CHAR_W'($urandom), address, 1'b0, '0);
      end else if (r < 55) begin
        send_command(MODE_CLEAR_ROW, CHAR_W'($urandom), address, 1'b0, '0);
      end else if (r < 200) begin
        if ($urandom_range(0, 9) != 0) address = ADDR_W'($urandom_range(0, CELLS - 1));
        else address = ADDR_W'($urandom_range(CELLS, ADDR_SPAN - 1));
        send_command(MODE_READ, CHAR_W'($urandom), address, 1'b0, '0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE));
        else if (r < 85) begin
          case ($urandom_range(0, 4))
            0: ch = CHAR_BS;
            1: ch = CHAR_TAB;
            2: ch = CHAR_CR;
            3: ch = CHAR_LF;
            default: ch = CHAR_W'($urandom_range(0, CHAR_SPACE - 1));
          endcase
        end else ch = CHAR_W'($urandom_range(CHAR_FIRST_HIGH, 8'hFF));
        send_command(MODE_PUT, ch, address, 1'b0, '0);
      end
    end else if (kind < 75) begin
      // a line of text, often long enough to wrap
      len = $urandom_range(4, 40);
      repeat (len) begin
        send_command(MODE_PUT, CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE)),
                     ADDR_W'($urandom), 1'b0, '0);
      end
    end else if (kind < 83) begin
      // tabs walk to the right edge and wrap, with a few characters between
      len = $urandom_range(2, 12);
      repeat (len) begin
        if ($urandom_range(0, 3) == 0) ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE));
        else ch = CHAR_TAB;
        send_command(MODE_PUT, ch, ADDR_W'($urandom), 1'b0, '0);
      end
    end else if (kind < 91) begin
      // line feeds reach the bottom row and scroll
      len = $urandom_range(1, 28);
      repeat (len) begin
        if ($urandom_range(0, 3) == 0) ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE));
        else ch = CHAR_LF;
        send_command(MODE_PUT, ch, ADDR_W'($urandom), 1'b0, '0);
      end
    end else begin
      // read back cells around the cursor
      len = $urandom_range(2, 10);
      repeat (len) begin
        base_row = row_shadow;
        if (base_row > 0 && $urandom_range(0, 1) == 1) base_row--;
        address = ADDR_W'(base_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
        send_command(MODE_READ, CHAR_W'($urandom), address, 1'b0, '0);
      end
    end
  endtask

  // stop sending and wait until the block has gone quiet
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    attribute_shadow = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = random_pause();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // compare every result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    cursor_result_t got;
    cursor_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RESULT_W-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result position %0d", got.position));
      end else begin
        want = pending_results.pop_front();
        if (got.position !== want.position)
          report_mismatch($sformatf("cursor_position got %0d want %0d",
                                    got.position, want.position));
        if (got.column !== want.column)
          report_mismatch($sformatf("cursor_column got %0d want %0d", got.column, want.column));
        if (got.row !== want.row)
          report_mismatch($sformatf("cursor_row got %0d want %0d", got.row, want.row));
        if (got.read_data !== want.read_data)
          report_mismatch($sformatf("read_data got %h want %h", got.read_data, want.read_data));
      end
    end
  end

  initial begin
    #(WATCHDOG_NS);
    $display("text_console_cursor_scroll_tb NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    logic [ATTR_W-1:0] attribute;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_PUT;
    mismatch_count   = 0;
    commands_counted = 0;
    calm             = 1'b0;
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = '0;
    column_shadow    = 0;
    row_shadow       = 0;
    attribute_shadow = ATTR_RESET;

    // typed results: data, row, column, position
    directed_rows = '{
      '{MODE_READ,         8'h00,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd0,  11'd0}},
      '{MODE_READ,         8'h00,      11'd1999, 1'b1, {16'h0000, 5'd0, 7'd0,  11'd0}},
      '{MODE_READ,         8'h00,      11'd2047, 1'b1, {16'h0000, 5'd0, 7'd0,  11'd0}},
      '{MODE_PUT,          8'h41,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd1,  11'd1}},
      '{MODE_READ,         8'h00,      11'd0,    1'b1, {16'h0F41, 5'd0, 7'd1,  11'd1}},
      '{MODE_PUT,          CHAR_BS,    11'd0,    1'b1, {16'h0000, 5'd0, 7'd0,  11'd0}},
      '{MODE_PUT,          CHAR_BS,    11'd0,    1'b1, {16'h0000, 5'd0, 7'd0,  11'd0}},
      '{MODE_PUT,          CHAR_TAB,   11'd0,    1'b1, {16'h0000, 5'd0, 7'd8,  11'd8}},
      '{MODE_PUT,          8'h7F,      11'd0,    1'b0, '0},
      '{MODE_PUT,          CHAR_SPACE, 11'd0,    1'b0, '0},
      '{MODE_PUT,          8'h00,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd10, 11'd10}},
      '{MODE_PUT,          8'h1F,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd10, 11'd10}},
      '{MODE_PUT,          8'h80,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd10, 11'd10}},
      '{MODE_PUT,          8'hFF,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd10, 11'd10}},
      '{MODE_PUT,          8'h0B,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd10, 11'd10}},
      '{MODE_PUT,          CHAR_CR,    11'd0,    1'b1, {16'h0000, 5'd0, 7'd0,  11'd0}},
      '{MODE_PUT,          CHAR_LF,    11'd0,    1'b1, {16'h0000, 5'd1, 7'd0,  11'd80}},
      '{MODE_PUT,          8'h5A,      11'd0,    1'b1, {16'h0000, 5'd1, 7'd1,  11'd81}},
      '{MODE_READ,         8'h00,      11'd8,    1'b1, {16'h0F7F, 5'd1, 7'd1,  11'd81}},
      '{MODE_CLEAR_ROW,    8'h00,      11'd0,    1'b1, {16'h0000, 5'd1, 7'd0,  11'd80}},
      '{MODE_READ,         8'h00,      11'd80,   1'b1, {16'h0F20, 5'd1, 7'd0,  11'd80}},
      '{MODE_CLEAR_SCREEN, 8'h00,      11'd0,    1'b1, {16'h0000, 5'd0, 7'd0,  11'd0}},
      '{MODE_READ,         8'h00,      11'd1999, 1'b1, {16'h0F20, 5'd0, 7'd0,  11'd0}}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table with the reset attribute
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].mode, directed_rows[i].char_code, directed_rows[i].address,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each under a new attribute, one of them without gaps
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      case (p)
        0: attribute = 8'h00;
        1: attribute = 8'hFF;
        default: attribute = ATTR_W'($urandom);
      endcase
      write_attribute(attribute);
      calm = (p == 2);
      commands_counted = 0;
      while (commands_counted < PHASE_ITEMS) send_random_run();
    end

    drain_and_settle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("text_console_cursor_scroll_tb OK");
    end else begin
      $display("text_console_cursor_scroll_tb NOT OK");
    end
    $finish;
  end

endmodule
